// File: src/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg
// shared types and constants for the triangle edge adjacency matcher
// ----------------------------------------------------------------------------
package tem_pkg;

  localparam int TABLE_SLOTS   = 8192;
  localparam int MAX_TRIANGLES = 1365;
  localparam int VERTEX_BITS   = 16;

  localparam int IDX_W    = $clog2(TABLE_SLOTS);
  localparam int KEY_W    = 2 * VERTEX_BITS;
  localparam int TRI_W    = 11;
  localparam int EDGE_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MATCHED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd3;

  localparam logic [EDGE_W-1:0] EDGE_AB = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_BC = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_CA = 2'd2;

  localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
  localparam int          MIX_SH1    = 30;
  localparam int          MIX_SH2    = 27;
  localparam int          MIX_SH3    = 31;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [TRI_W-1:0]  tri_num;
    logic [EDGE_W-1:0] edge_num;
  } slot_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TRI_W-1:0]    triangle_index;
    logic [EDGE_W-1:0]   edge_index;
    logic [TRI_W-1:0]    neighbor_triangle;
    logic [EDGE_W-1:0]   neighbor_edge;
    logic                last;
  } result_t;

  typedef enum logic [2:0] {
    H_IDLE,
    H_PREP,
    H_M0,
    H_M1,
    H_M2,
    H_M3,
    H_FIN
  } hstep_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_CLR_RPT,
    S_IDLE,
    S_REJECT,
    S_HASH,
    S_HASH_WAIT,
    S_RD,
    S_CHK
  } tem_state_t;

endpackage

// File: src/triangle_edge_adjacency_matcher_top.sv
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_matcher_top
// edge adjacency matcher: hashes each triangle edge into an open addressing
// table and reports the first triangle that shared it
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  kind, vertex_a, vertex_b, vertex_c
//   out_     out  out_valid/out_stall status, triangle/edge index, neighbor, last
//
// an add item is accepted, then each edge runs hash start, ten hash steps on
// the shared multiplier, hash done, slot read and slot check; each extra
// linear probe on the ram port repeats the slot read and slot check
// a triangle gives three transfers, a clear or reject item one
// after reset and after each clear item the table is swept, one slot a
// cycle, over all 8192 slots, with in_stall high
// results sit in an output register; a stalled output only holds the sequencer
// when it has a new result to place
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_vertex_a,
  input  logic [15:0] in_vertex_b,
  input  logic [15:0] in_vertex_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [10:0] out_triangle_index,
  output logic [1:0]  out_edge_index,
  output logic [10:0] out_neighbor_triangle,
  output logic [1:0]  out_neighbor_edge,
  output logic        out_last
);

  localparam int VB = tem_pkg::VERTEX_BITS;

  tem_pkg::tem_state_t       state_r, state_nxt;
  logic [tem_pkg::IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                       clr_rpt_r, clr_rpt_nxt;
  logic [tem_pkg::TRI_W-1:0]  tri_cnt_r, tri_cnt_nxt;
  logic [tem_pkg::EDGE_W-1:0] edge_r, edge_nxt;
  logic [tem_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [tem_pkg::IDX_W-1:0]  probes_r, probes_nxt;
  logic [VB-1:0]              va_r, va_nxt;
  logic [VB-1:0]              vb_r, vb_nxt;
  logic [VB-1:0]              vc_r, vc_nxt;
  logic [tem_pkg::KEY_W-1:0]  tag_r, tag_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tem_pkg::result_t           out_r, out_nxt;

  logic [VB-1:0]              end0, end1, lo, hi;
  logic [63:0]                hash_key;
  logic                       hash_start;
  logic                       hash_done;
  logic [tem_pkg::IDX_W-1:0]  hash_idx;
  logic                       ram_we;
  logic [tem_pkg::IDX_W-1:0]  ram_waddr;
  tem_pkg::slot_t             ram_wdata;
  tem_pkg::slot_t             rd_slot;
  logic                       out_free;
  logic                       slot_hit;
  logic                       last_probe;

  tem_ram #(
    .WIDTH ($bits(tem_pkg::slot_t)),
    .DEPTH (tem_pkg::TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (rd_slot)
  );

  tem_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .done  (hash_done),
    .idx   (hash_idx)
  );

  always_comb begin
    unique case (edge_r)
      tem_pkg::EDGE_AB: begin
        end0 = va_r;
        end1 = vb_r;
      end
      tem_pkg::EDGE_BC: begin
        end0 = vb_r;
        end1 = vc_r;
      end
      default: begin
        end0 = vc_r;
        end1 = va_r;
      end
    endcase
  end

  assign lo       = (end0 > end1) ? end1 : end0;
  assign hi       = (end0 > end1) ? end0 : end1;
  assign hash_key = {32'(lo), 32'(hi)} + 64'd1;

  assign out_free   = !out_valid_r || !out_stall;
  assign slot_hit   = rd_slot.valid && (rd_slot.key == tag_r);
  assign last_probe = (probes_r == {tem_pkg::IDX_W{1'b1}});

  assign in_stall              = (state_r != tem_pkg::S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_triangle_index    = out_r.triangle_index;
  assign out_edge_index        = out_r.edge_index;
  assign out_neighbor_triangle = out_r.neighbor_triangle;
  assign out_neighbor_edge     = out_r.neighbor_edge;
  assign out_last              = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tem_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      clr_rpt_r   <= 1'b0;
      tri_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_rpt_r   <= clr_rpt_nxt;
      tri_cnt_r   <= tri_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    edge_r   <= edge_nxt;
    idx_r    <= idx_nxt;
    probes_r <= probes_nxt;
    va_r     <= va_nxt;
    vb_r     <= vb_nxt;
    vc_r     <= vc_nxt;
    tag_r    <= tag_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_rpt_nxt   = clr_rpt_r;
    tri_cnt_nxt   = tri_cnt_r;
    edge_nxt      = edge_r;
    idx_nxt       = idx_r;
    probes_nxt    = probes_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    vc_nxt        = vc_r;
    tag_nxt       = tag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    hash_start    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;

    unique case (state_r)
      tem_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {tem_pkg::IDX_W{1'b1}}) begin
          state_nxt = clr_rpt_r ? tem_pkg::S_CLR_RPT : tem_pkg::S_IDLE;
        end
      end
      tem_pkg::S_CLR_RPT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = tem_pkg::ST_CLEARED;
          out_nxt.last   = 1'b1;
          state_nxt      = tem_pkg::S_IDLE;
        end
      end
      tem_pkg::S_IDLE: begin
        if (in_valid) begin
          va_nxt   = in_vertex_a[VB-1:0];
          vb_nxt   = in_vertex_b[VB-1:0];
          vc_nxt   = in_vertex_c[VB-1:0];
          edge_nxt = tem_pkg::EDGE_AB;
          priority if (in_kind) begin
            tri_cnt_nxt  = '0;
            clr_addr_nxt = '0;
            clr_rpt_nxt  = 1'b1;
            state_nxt    = tem_pkg::S_CLEAR;
          end else if (tri_cnt_r == tem_pkg::TRI_W'(tem_pkg::MAX_TRIANGLES)) begin
            state_nxt = tem_pkg::S_REJECT;
          end else begin
            state_nxt = tem_pkg::S_HASH;
          end
        end
      end
      tem_pkg::S_REJECT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.status         = tem_pkg::ST_REJECTED;
          out_nxt.triangle_index = tri_cnt_r;
          out_nxt.last           = 1'b1;
          state_nxt              = tem_pkg::S_IDLE;
        end
      end
      tem_pkg::S_HASH: begin
        hash_start = 1'b1;
        tag_nxt    = {lo, hi};
        state_nxt  = tem_pkg::S_HASH_WAIT;
      end
      tem_pkg::S_HASH_WAIT: begin
        if (hash_done) begin
          idx_nxt    = hash_idx;
          probes_nxt = '0;
          state_nxt  = tem_pkg::S_RD;
        end
      end
      tem_pkg::S_RD: begin
        state_nxt = tem_pkg::S_CHK;
      end
      tem_pkg::S_CHK: begin
        if (rd_slot.valid && !slot_hit && !last_probe) begin
          idx_nxt    = idx_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = tem_pkg::S_RD;
        end else if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.status         = slot_hit ? tem_pkg::ST_MATCHED : tem_pkg::ST_UNMATCHED;
          out_nxt.triangle_index = tri_cnt_r;
          out_nxt.edge_index     = edge_r;
          out_nxt.last           = (edge_r == tem_pkg::EDGE_CA);
          if (slot_hit) begin
            out_nxt.neighbor_triangle = rd_slot.tri_num;
            out_nxt.neighbor_edge     = rd_slot.edge_num;
          end
          if (!rd_slot.valid) begin
            ram_we             = 1'b1;
            ram_wdata.valid    = 1'b1;
            ram_wdata.key      = tag_r;
            ram_wdata.tri_num  = tri_cnt_r;
            ram_wdata.edge_num = edge_r;
          end
          if (edge_r == tem_pkg::EDGE_CA) begin
            tri_cnt_nxt = tri_cnt_r + 1'b1;
            state_nxt   = tem_pkg::S_IDLE;
          end else begin
            edge_nxt  = edge_r + 1'b1;
            state_nxt = tem_pkg::S_HASH;
          end
        end
      end
      default: begin
        state_nxt = tem_pkg::S_IDLE;
      end
    endcase
  end

  // one item at a time: an accepted item always blocks the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in back-to-back cycles");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tem_pkg::ST_CLEARED || out_status == tem_pkg::ST_REJECTED)
    |-> out_last)
    else $error("clear or reject result without last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tri_cnt_r <= tem_pkg::TRI_W'(tem_pkg::MAX_TRIANGLES))
    else $error("triangle count beyond capacity");

  a_probe_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tem_pkg::S_CHK |-> $past(state_r) == tem_pkg::S_RD ||
      $past(state_r) == tem_pkg::S_CHK)
    else $error("slot check without a prior read");

endmodule

// File: src/tem_ram.sv
// ----------------------------------------------------------------------------
// tem_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tem_hash.sv
// ----------------------------------------------------------------------------
// tem_hash
// splitmix64 finalizer on one shared 32x32 multiplier, gives the home slot
// ----------------------------------------------------------------------------
module tem_hash (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [63:0]             key,
  output logic                    done,
  output logic [tem_pkg::IDX_W-1:0] idx
);

  tem_pkg::hstep_t step_r, step_nxt;
  logic            round_r, round_nxt;
  logic [63:0]     x_r, x_nxt;
  logic [63:0]     m_r, m_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;
  logic [63:0]     mix_c;
  logic [63:0]     h_fin;

  assign mix_c = round_r ? tem_pkg::MIX_C2 : tem_pkg::MIX_C1;
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign h_fin = x_r ^ (x_r >> tem_pkg::MIX_SH3);
  assign idx   = h_fin[tem_pkg::IDX_W-1:0];
  assign done  = (step_r == tem_pkg::H_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= tem_pkg::H_IDLE;
      round_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      round_r <= round_nxt;
    end
    x_r    <= x_nxt;
    m_r    <= m_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  always_comb begin
    step_nxt  = step_r;
    round_nxt = round_r;
    x_nxt     = x_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    mul_a     = m_r[31:0];
    mul_b     = mix_c[31:0];
    unique case (step_r)
      tem_pkg::H_IDLE: begin
        if (start) begin
          x_nxt     = key + tem_pkg::MIX_GOLDEN;
          round_nxt = 1'b0;
          step_nxt  = tem_pkg::H_PREP;
        end
      end
      tem_pkg::H_PREP: begin
        m_nxt    = round_r ? (x_r ^ (x_r >> tem_pkg::MIX_SH2))
                           : (x_r ^ (x_r >> tem_pkg::MIX_SH1));
        step_nxt = tem_pkg::H_M0;
      end
      tem_pkg::H_M0: begin
        prod_nxt = mul_p;
        step_nxt = tem_pkg::H_M1;
      end
      tem_pkg::H_M1: begin
        mul_b    = mix_c[63:32];
        acc_nxt  = prod_r;
        prod_nxt = mul_p;
        step_nxt = tem_pkg::H_M2;
      end
      tem_pkg::H_M2: begin
        mul_a    = m_r[63:32];
        acc_nxt  = acc_r + {prod_r[31:0], 32'b0};
        prod_nxt = mul_p;
        step_nxt = tem_pkg::H_M3;
      end
      tem_pkg::H_M3: begin
        x_nxt = acc_r + {prod_r[31:0], 32'b0};
        if (round_r) begin
          step_nxt = tem_pkg::H_FIN;
        end else begin
          round_nxt = 1'b1;
          step_nxt  = tem_pkg::H_PREP;
        end
      end
      tem_pkg::H_FIN: begin
        step_nxt = tem_pkg::H_IDLE;
      end
      default: begin
        step_nxt = tem_pkg::H_IDLE;
      end
    endcase
  end

endmodule
